/* rtl/ubx_pkg.sv */
`timescale 1ns / 1ps

package ubx_pkg;

  // Frame delimiters and NAV-PVT identification
  localparam logic [7:0]  SyncFirst  = 8'hB5;
  localparam logic [7:0]  SyncSecond = 8'h62;
  localparam logic [7:0]  PvtClass   = 8'h01;
  localparam logic [7:0]  PvtId      = 8'h07;
  localparam logic [15:0] PvtMinLen  = 16'd92;

  // Reset value of the max payload register
  localparam logic [15:0] MaxPayloadReset = 16'd256;

  // Parser phases, one-hot
  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b0_0000_0001,
    PH_SYNC2   = 9'b0_0000_0010,
    PH_CLASS   = 9'b0_0000_0100,
    PH_ID      = 9'b0_0000_1000,
    PH_LEN1    = 9'b0_0001_0000,
    PH_LEN2    = 9'b0_0010_0000,
    PH_PAYLOAD = 9'b0_0100_0000,
    PH_CKA     = 9'b0_1000_0000,
    PH_CKB     = 9'b1_0000_0000
  } phase_e;

endpackage

/* rtl/ubx_frame_parser.sv */
`timescale 1ns / 1ps
// A result word appears in the cycle after its input byte is accepted.
// One byte per cycle unless the result register is stalled; phase machine and checksum
// updates for a byte are combinational, and the result register frees as it drains.
// Reset: asynchronous, active low; parser returns to sync hunt, sums and frame
// fields clear, max payload register reads 256, result register empties.
module ubx_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic        frame_done_o,
  output logic        frame_good_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  output logic [15:0] msg_length_o,
  output logic        nav_pvt_match_o
);
  import ubx_pkg::*;

  logic [15:0] max_payload_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] length_q, length_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  rx_sum_a_q, rx_sum_a_d;

  logic        out_valid_q;
  logic        pv_q, pv_d;
  logic [7:0]  pb_q, pb_d;
  logic [15:0] pi_q, pi_d;
  logic        done_q, done_d;
  logic        good_q, good_d;
  logic [7:0]  oc_q, oc_d;
  logic [7:0]  oi_q, oi_d;
  logic [15:0] ol_q, ol_d;
  logic        pvt_q, pvt_d;

  logic        in_acc;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] pos_inc;

  // Handshake: a new byte enters whenever the result register is free or draining
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Fletcher step on the incoming byte
  assign add_a    = sum_a_q + data_byte_i;
  assign add_b    = sum_b_q + add_a;
  assign len_full = {data_byte_i, length_q[7:0]};
  assign pos_inc  = pos_q + 16'd1;

  // Phase machine and result word for one byte
  always_comb begin
    phase_d    = phase_q;
    class_d    = class_q;
    id_d       = id_q;
    length_d   = length_q;
    pos_d      = pos_q;
    sum_a_d    = sum_a_q;
    sum_b_d    = sum_b_q;
    rx_sum_a_d = rx_sum_a_q;
    pv_d       = 1'b0;
    pb_d       = 8'd0;
    pi_d       = 16'd0;
    done_d     = 1'b0;
    good_d     = 1'b0;
    pvt_d      = 1'b0;
    case (phase_q)
      PH_SYNC2: begin
        if (data_byte_i == SyncSecond) begin
          phase_d = PH_CLASS;
          sum_a_d = 8'd0;
          sum_b_d = 8'd0;
        end else if (data_byte_i == SyncFirst) begin
          phase_d = PH_SYNC2;
        end else begin
          phase_d = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        class_d = data_byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = PH_ID;
      end
      PH_ID: begin
        id_d    = data_byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        length_d = {8'd0, data_byte_i};
        sum_a_d  = add_a;
        sum_b_d  = add_b;
        phase_d  = PH_LEN2;
      end
      PH_LEN2: begin
        pos_d = 16'd0;
        if (len_full > max_payload_q) begin
          // overlong frame: drop everything and hunt again
          phase_d    = PH_SYNC1;
          class_d    = 8'd0;
          id_d       = 8'd0;
          length_d   = 16'd0;
          sum_a_d    = 8'd0;
          sum_b_d    = 8'd0;
          rx_sum_a_d = 8'd0;
        end else begin
          length_d = len_full;
          sum_a_d  = add_a;
          sum_b_d  = add_b;
          phase_d  = (len_full == 16'd0) ? PH_CKA : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pv_d    = 1'b1;
        pb_d    = data_byte_i;
        pi_d    = pos_q;
        sum_a_d = add_a;
        sum_b_d = add_b;
        pos_d   = pos_inc;
        if (pos_inc >= length_q) begin
          phase_d = PH_CKA;
        end
      end
      PH_CKA: begin
        rx_sum_a_d = data_byte_i;
        phase_d    = PH_CKB;
      end
      PH_CKB: begin
        done_d = 1'b1;
        good_d = (rx_sum_a_q == sum_a_q) && (data_byte_i == sum_b_q);
        pvt_d  = good_d && (class_q == PvtClass) && (id_q == PvtId) &&
                 (length_q >= PvtMinLen);
        // frame finished: clear for the next one
        phase_d    = PH_SYNC1;
        class_d    = 8'd0;
        id_d       = 8'd0;
        length_d   = 16'd0;
        pos_d      = 16'd0;
        sum_a_d    = 8'd0;
        sum_b_d    = 8'd0;
        rx_sum_a_d = 8'd0;
      end
      default: begin
        // sync hunt; undefined codes fall in here too
        phase_d = (data_byte_i == SyncFirst) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
    // frame fields shown after the byte, except the finished frame on CKB
    if (phase_q == PH_CKB) begin
      oc_d = class_q;
      oi_d = id_q;
      ol_d = length_q;
    end else begin
      oc_d = class_d;
      oi_d = id_d;
      ol_d = length_d;
    end
  end

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC1;
      class_q    <= 8'd0;
      id_q       <= 8'd0;
      length_q   <= 16'd0;
      pos_q      <= 16'd0;
      sum_a_q    <= 8'd0;
      sum_b_q    <= 8'd0;
      rx_sum_a_q <= 8'd0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      class_q    <= class_d;
      id_q       <= id_d;
      length_q   <= length_d;
      pos_q      <= pos_d;
      sum_a_q    <= sum_a_d;
      sum_b_q    <= sum_b_d;
      rx_sum_a_q <= rx_sum_a_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pv_q   <= pv_d;
      pb_q   <= pb_d;
      pi_q   <= pi_d;
      done_q <= done_d;
      good_q <= good_d;
      oc_q   <= oc_d;
      oi_q   <= oi_d;
      ol_q   <= ol_d;
      pvt_q  <= pvt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = pv_q;
  assign payload_byte_o  = pb_q;
  assign payload_index_o = pi_q;
  assign frame_done_o    = done_q;
  assign frame_good_o    = good_q;
  assign msg_class_o     = oc_q;
  assign msg_id_o        = oi_q;
  assign msg_length_o    = ol_q;
  assign nav_pvt_match_o = pvt_q;

  // Checks
  a_acc_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted byte produced no result word");

  a_pvt_implies_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pvt_q) |-> (done_q && good_q && oc_q == PvtClass &&
                                oi_q == PvtId && ol_q >= PvtMinLen))
    else $error("nav_pvt_match without a good NAV-PVT frame");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pv_q) |-> (pi_q < ol_q && !done_q))
    else $error("payload index outside frame length");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_PAYLOAD) |-> (length_q != 16'd0 && pos_q < length_q))
    else $error("payload phase with exhausted length");

endmodule
